// File: sv/graph_m_coloring_search_unit_macros.svh
// Assertion helpers for the coloring search unit.
`ifndef GRAPH_M_COLORING_SEARCH_UNIT_MACROS_SVH
`define GRAPH_M_COLORING_SEARCH_UNIT_MACROS_SVH
`define GMC_ASSERT_IMPL(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define GMC_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`endif

// File: sv/gmc_pkg.sv
package gmc_pkg;
    localparam logic OP_WRITE_ROW = 1'b0;
    localparam logic OP_SOLVE     = 1'b1;
    localparam int   CFG_NODES    = 0;
    localparam int   CFG_COLORS   = 1;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic clear;    // zero all colors
        logic bump;     // increment color of cursor cell
        logic zero_cur; // zero color of cursor cell
        logic shift;    // rotate colors toward output
    } gmc_ctl_t;
endpackage

// File: sv/gmc_cell.sv
// One node of the search: holds its adjacency row and color, compares its color
// against the cursor node's color and reports a conflict.
module gmc_cell
    import gmc_pkg::*;
#(
    parameter int MAX_NODES  = 16,
    parameter int COLOR_W    = 5,
    parameter int IDX_W      = 4,
    parameter int IDX        = 0
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  gmc_ctl_t             ctl,
    input  logic                 row_we,
    input  logic [MAX_NODES-1:0] row_bits,
    input  logic [IDX_W-1:0]     cursor,
    input  logic [COLOR_W-1:0]   cur_color,
    input  logic [MAX_NODES-1:0] cur_row,
    input  logic [COLOR_W-1:0]   shift_in,
    input  logic                 conf_in,
    output logic [COLOR_W-1:0]   color,
    output logic [MAX_NODES-1:0] row,
    output logic                 conf_out
);
    localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

    logic [MAX_NODES-1:0] row_reg;
    logic [COLOR_W-1:0]   color_reg, color_next;
    logic                 joined;
    logic                 hit;

    always_ff @(posedge clk)
    begin
        if (row_we)
        begin
            row_reg <= row_bits;
        end
    end

    always_comb
    begin
        color_next = color_reg;
        if (ctl.clear)
        begin
            color_next = '0;
        end
        else if (ctl.shift)
        begin
            color_next = shift_in;
        end
        else if (cursor == MY_IDX)
        begin
            if (ctl.zero_cur)
            begin
                color_next = '0;
            end
            else if (ctl.bump)
            begin
                color_next = color_reg + COLOR_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_reg <= '0;
        end
        else
        begin
            color_reg <= color_next;
        end
    end

    // only cells below the cursor take part; the cursor cell is skipped
    assign joined   = row_reg[cursor] | cur_row[IDX];
    assign hit      = (MY_IDX < cursor) && (color_reg == cur_color) && joined;
    assign conf_out = conf_in | hit;
    assign color    = color_reg;
    assign row      = row_reg;
endmodule

// File: sv/graph_m_coloring_search_unit.sv
// Channel  Dir  Signals                                   Beat
// in       in   in_valid/in_ready, opcode,row_index,row_bits  row write or solve
// out      out  out_valid/out_ready, found,node_color,last    one node color
// cfg      in   cfg_we, cfg_index, cfg_data                   register write
// A solve alternates the try and check states per color trial, plus a try step
// per backtrack, data dependent, set by the single cursor walking the chain of
// node cells, then one beat per node, or one beat when no coloring exists.
// Output beats rotate the color chain one cell per accepted beat.
// Reset (rst_n low, async) clears colors, state and the valid flags; rows are
// undefined until written. out_valid holds under stall; no item is taken
// while a search or its output is in progress.
`include "graph_m_coloring_search_unit_macros.svh"
module graph_m_coloring_search_unit
    import gmc_pkg::*;
#(
    parameter int MAX_NODES  = 16,
    parameter int MAX_COLORS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [3:0]  row_index,
    input  logic [15:0] row_bits,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        found,
    output logic [4:0]  node_color,
    output logic        last,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int IDX_W   = $clog2(MAX_NODES);
    localparam int CNT_W   = $clog2(MAX_NODES + 1);
    localparam int COLOR_W = $clog2(MAX_COLORS + 1);

    typedef enum logic [2:0] {S_IDLE, S_TRY, S_CHECK, S_EMIT, S_FAIL} state_t;

    state_t               state_reg;
    logic [4:0]           nodes_reg, colors_reg;
    logic [IDX_W-1:0]     cursor_reg;
    logic [CNT_W-1:0]     emit_reg;
    logic [CNT_W-1:0]     n_eff;
    logic [COLOR_W-1:0]   m_eff;
    gmc_ctl_t             ctl;
    logic [COLOR_W-1:0]   colors [MAX_NODES];
    logic [MAX_NODES-1:0] rows [MAX_NODES];
    logic                 conf [MAX_NODES+1];
    logic [COLOR_W-1:0]   cur_color;
    logic [MAX_NODES-1:0] cur_row;
    logic [MAX_NODES-1:0] wide_bits;
    logic                 accept, row_write;

    assign accept    = in_valid && in_ready;
    assign row_write = accept && opcode == OP_WRITE_ROW && 32'(row_index) < MAX_NODES;
    assign in_ready  = state_reg == S_IDLE;
    assign wide_bits = MAX_NODES'(row_bits);

    // saturate the configuration to the storage
    always_comb
    begin
        if (nodes_reg == 5'd0)
            n_eff = CNT_W'(1);
        else if (32'(nodes_reg) > MAX_NODES)
            n_eff = CNT_W'(MAX_NODES);
        else
            n_eff = CNT_W'(nodes_reg);
        if (32'(colors_reg) > MAX_COLORS)
            m_eff = COLOR_W'(MAX_COLORS);
        else
            m_eff = COLOR_W'(colors_reg);
    end

    assign cur_color = colors[cursor_reg];
    assign cur_row   = rows[cursor_reg];
    assign conf[0]   = 1'b0;

    genvar g;
    generate
        for (g = 0; g < MAX_NODES; g++)
        begin : g_cell
            gmc_cell #(
                .MAX_NODES (MAX_NODES),
                .COLOR_W   (COLOR_W),
                .IDX_W     (IDX_W),
                .IDX       (g)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .row_we    (row_write && 32'(row_index) == g),
                .row_bits  (wide_bits),
                .cursor    (cursor_reg),
                .cur_color (cur_color),
                .cur_row   (cur_row),
                .shift_in  (colors[(g + 1) % MAX_NODES]),
                .conf_in   (conf[g]),
                .color     (colors[g]),
                .row       (rows[g]),
                .conf_out  (conf[g+1])
            );
        end
    endgenerate

    always_comb
    begin
        ctl = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                ctl.clear = accept && opcode == OP_SOLVE;
            end
            S_TRY:
            begin
                ctl.bump = cur_color < m_eff;
                ctl.zero_cur = !(cur_color < m_eff);
            end
            S_FAIL:
            begin
                ctl.clear = 1'b1;
            end
            S_EMIT:
            begin
                ctl.shift = out_ready;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            nodes_reg  <= 5'd1;
            colors_reg <= 5'd1;
            cursor_reg <= '0;
            emit_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == 1'(CFG_NODES))
                    nodes_reg <= cfg_data;
                else
                    colors_reg <= cfg_data;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    if (accept && opcode == OP_SOLVE)
                    begin
                        cursor_reg <= '0;
                        emit_reg   <= '0;
                        state_reg  <= (m_eff == '0) ? S_FAIL : S_TRY;
                    end
                end
                S_TRY:
                begin
                    // advance color, or drop back a node when exhausted
                    if (cur_color < m_eff)
                        state_reg <= S_CHECK;
                    else if (cursor_reg == '0)
                        state_reg <= S_FAIL;
                    else
                        cursor_reg <= cursor_reg - IDX_W'(1);
                end
                S_CHECK:
                begin
                    if (conf[MAX_NODES])
                        state_reg <= S_TRY;
                    else if (CNT_W'(cursor_reg) + CNT_W'(1) >= n_eff)
                        state_reg <= S_EMIT;
                    else
                    begin
                        cursor_reg <= cursor_reg + IDX_W'(1);
                        state_reg  <= S_TRY;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + CNT_W'(1);
                        if (emit_reg + CNT_W'(1) >= n_eff)
                            state_reg <= S_IDLE;
                    end
                end
                S_FAIL:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // colors above the cursor stay zero after backtracking, so the chain is clean
    assign out_valid  = state_reg == S_EMIT || state_reg == S_FAIL;
    assign found      = state_reg == S_EMIT;
    assign node_color = (state_reg == S_EMIT) ? 5'(colors[0]) : 5'd0;
    assign last       = (state_reg == S_FAIL) ||
                        (state_reg == S_EMIT && emit_reg + CNT_W'(1) >= n_eff);

    `GMC_ASSERT_IMPL(a_busy_not_ready, clk, rst_n, !(out_valid && in_ready),
        "input taken while result pending")
    `GMC_ASSERT_NEXT(a_fail_clean, clk, rst_n, state_reg == S_FAIL && out_ready,
        colors[0] == '0, "colors not cleared after fail")
    `GMC_ASSERT_IMPL(a_emit_color, clk, rst_n,
        !(found && (node_color == 5'd0 || 32'(node_color) > MAX_COLORS)),
        "emitted color out of range")
endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
    import gmc_pkg::*;

    typedef struct packed {
        logic        op;
        logic [3:0]  idx;
        logic [15:0] bits;
    } beat_in_t;

    typedef struct packed {
        logic       fnd;
        logic [4:0] color;
        logic       lst;
    } beat_out_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic        opcode;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic        out_valid;
    logic        out_ready;
    logic        found;
    logic [4:0]  node_color;
    logic        last;
    logic        cfg_we;
    logic        cfg_index;
    logic [4:0]  cfg_data;

    graph_m_coloring_search_unit DUT (.*);

    // Stimulus and prediction state
    beat_in_t    pending_q[$];
    beat_out_t   color_q[$];
    logic [15:0] graph_rows[16];
    logic [4:0]  shadow_nodes;
    logic [4:0]  shadow_colors;
    int          err_count;
    bit          calm;
    int          send_gap;
    int          recv_gap;
    int          sent_count;

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    task automatic report(input string what);
        $display("tb: mismatch: %s", what);
        err_count++;
    endtask

    // Depth-first search for the first coloring, ascending colors, node 0 first.
    // Returns 1 and fills col when one exists.
    function automatic bit color_graph(input int n, input int m, output int col[16]);
        int  k;
        bit  ok;
        for (int i = 0; i < 16; i++)
            col[i] = 0;
        if (m == 0)
            return 0;
        k = 0;
        forever
        begin
            col[k]++;
            if (col[k] > m)
            begin
                col[k] = 0;
                if (k == 0)
                    return 0;
                k--;
                continue;
            end
            ok = 1;
            for (int j = 0; j < k; j++)
                if (col[j] == col[k] && (graph_rows[k][j] || graph_rows[j][k]))
                    ok = 0;
            if (ok)
            begin
                k++;
                if (k >= n)
                    return 1;
                col[k] = 0;
            end
        end
    endfunction

    // Work out the beats that one accepted item causes.
    task automatic predict_beat(input beat_in_t b);
        int        n;
        int        m;
        int        col[16];
        beat_out_t e;
        if (b.op == OP_WRITE_ROW)
        begin
            graph_rows[b.idx] = b.bits;
            return;
        end
        n = shadow_nodes;
        if (n == 0)
            n = 1;
        if (n > 16)
            n = 16;
        m = shadow_colors;
        if (m > 16)
            m = 16;
        if (!color_graph(n, m, col))
        begin
            e.fnd = 1'b0;
            e.color = 5'd0;
            e.lst = 1'b1;
            color_q.push_back(e);
        end
        else
        begin
            for (int i = 0; i < n; i++)
            begin
                e.fnd = 1'b1;
                e.color = 5'(col[i]);
                e.lst = (i == n - 1);
                color_q.push_back(e);
            end
        end
    endtask

    // Driver: hold the beat until taken, then advance or idle a burst.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid  <= 1'b0;
            opcode    <= OP_WRITE_ROW;
            row_index <= 4'd0;
            row_bits  <= 16'd0;
            send_gap  = 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_valid)
                predict_beat('{opcode, row_index, row_bits});
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (pending_q.size() > 0 && (calm || $urandom_range(0, 4) != 0))
            begin
                beat_in_t nb;
                nb = pending_q.pop_front();
                in_valid  <= 1'b1;
                opcode    <= nb.op;
                row_index <= nb.idx;
                row_bits  <= nb.bits;
                sent_count++;
            end
            else
            begin
                in_valid <= 1'b0;
                if (!calm && pending_q.size() > 0)
                    send_gap = $urandom_range(1, 10);
            end
        end
    end

    // Monitor: check each color beat against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_gap  = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                beat_out_t e;
                if (color_q.size() == 0)
                    report($sformatf("unexpected beat found=%0d color=%0d last=%0d",
                                     found, node_color, last));
                else
                begin
                    e = color_q.pop_front();
                    if (found !== e.fnd)
                        report($sformatf("found %0d, want %0d", found, e.fnd));
                    if (node_color !== e.color)
                        report($sformatf("node_color %0d, want %0d", node_color, e.color));
                    if (last !== e.lst)
                        report($sformatf("last %0d, want %0d", last, e.lst));
                end
            end
            if (calm)
                out_ready <= 1'b1;
            else if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else if ($urandom_range(0, 5) == 0)
            begin
                recv_gap = $urandom_range(0, 9);
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Wait until every queued beat went in and every color came out, then
    // let a search that a trailing row write might have left settle.
    task automatic drain();
        while (pending_q.size() > 0 || in_valid || color_q.size() > 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input int idx, input logic [4:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= 1'(idx);
        cfg_data  <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_NODES)
            shadow_nodes = v;
        else
            shadow_colors = v;
    endtask

    task automatic push_row(input int r, input logic [15:0] bits);
        pending_q.push_back('{OP_WRITE_ROW, 4'(r), bits});
    endtask

    task automatic push_solve();
        pending_q.push_back('{OP_SOLVE, 4'($urandom), 16'($urandom)});
    endtask

    // One configured phase. Dense random graphs only where the search is
    // bounded: few nodes and colors, or colors at least as many as nodes.
    // Otherwise the graph stays empty so no deep backtracking can happen.
    task automatic random_phase(input int count);
        logic [4:0] n;
        logic [4:0] m;
        int         ne;
        int         me;
        bit         dense;
        if ($urandom_range(0, 1))
        begin
            n = 5'($urandom_range(0, 5));
            m = 5'($urandom_range(0, 5));
        end
        else
        begin
            n = 5'($urandom_range(6, 31));
            ne = (n > 16) ? 16 : n;
            m = ($urandom_range(0, 3) == 0) ? 5'($urandom_range(0, 31))
                                            : 5'($urandom_range(ne, 31));
        end
        ne = (n == 0) ? 1 : ((n > 16) ? 16 : n);
        me = (m > 16) ? 16 : m;
        dense = (ne <= 5) || (me >= ne);
        write_reg(CFG_NODES, n);
        write_reg(CFG_COLORS, m);
        for (int r = 0; r < 16; r++)
            push_row(r, dense ? 16'($urandom) & 16'($urandom) : 16'd0);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 2) == 0)
                push_row($urandom_range(0, 15), dense ? 16'($urandom) : 16'd0);
            else
                push_solve();
        end
        drain();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        opcode = OP_WRITE_ROW;
        row_index = 4'd0;
        row_bits = 16'd0;
        out_ready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = 1'b0;
        cfg_data = 5'd0;
        shadow_nodes = 5'd1;
        shadow_colors = 5'd1;
        err_count = 0;
        sent_count = 0;
        calm = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset config on an empty graph
        for (int r = 0; r < 16; r++)
            push_row(r, 16'd0);
        push_solve();
        drain();
        // Zero nodes acts as one; zero colors gives no coloring
        write_reg(CFG_NODES, 5'd0);
        push_solve();
        drain();
        write_reg(CFG_COLORS, 5'd0);
        push_solve();
        drain();
        // Full graph with self loops, all nodes and colors: colors 1..16
        write_reg(CFG_NODES, 5'd16);
        write_reg(CFG_COLORS, 5'd16);
        for (int r = 0; r < 16; r++)
            push_row(r, 16'hFFFF);
        push_solve();
        drain();
        // Saturating counts above the maximum
        write_reg(CFG_NODES, 5'd31);
        write_reg(CFG_COLORS, 5'd31);
        push_solve();
        drain();
        // Edges 0-1 and 0-2 only, two colors: 1,2,2
        write_reg(CFG_NODES, 5'd3);
        write_reg(CFG_COLORS, 5'd2);
        push_row(0, 16'h0006);
        push_row(1, 16'h0001);
        push_row(2, 16'h0000);
        push_solve();
        // Path 0-1-2 only one direction stored: 1,2,1
        push_row(2, 16'hFFF8);
        push_row(0, 16'h0002);
        push_row(1, 16'h0004);
        push_solve();
        drain();
        // Many nodes, one color, empty graph: all ones
        write_reg(CFG_NODES, 5'd16);
        write_reg(CFG_COLORS, 5'd1);
        for (int r = 0; r < 16; r++)
            push_row(r, 16'd0);
        push_solve();
        drain();

        while (sent_count < 270)
            random_phase($urandom_range(10, 30));
        calm = 1;
        random_phase(30);
        random_phase(20);

        if (err_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #30ms;
        $display("tb: failure");
        $finish;
    end
endmodule
